// ----- hdl/qdfs_pkg.sv -----
// Shared types and constants for the quoted delimited field splitter.
`default_nettype none
package qdfs_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        line_blank;
    logic [7:0]  field_number;
    logic [15:0] line_number;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic [7:0] comment_char;
  } cfg_t;

  typedef struct packed {
    logic      push0;
    logic      push1;
    out_item_t item0;
    out_item_t item1;
  } result_pair_t;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMENT   = 2'd1;

  localparam logic [1:0] KIND_CONTENT   = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] TAB_BYTE   = 8'h09;

  localparam logic [7:0] DELIMITER_RESET = 8'h3A;
  localparam logic [7:0] COMMENT_RESET   = 8'h23;

endpackage
`default_nettype wire

// ----- hdl/qdfs_parser.sv -----
// Parse state and per-byte splitting logic, up to two results per transfer.
`default_nettype none
module qdfs_parser #(
  parameter int unsigned     FIELD_COUNT_MAX = 255,
  parameter longint unsigned LINE_COUNT_MAX  = 65535
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire qdfs_pkg::in_item_t in_item,
  input  wire qdfs_pkg::cfg_t     cfg,
  output qdfs_pkg::result_pair_t  results
);

  localparam int unsigned FW = $clog2(64'(FIELD_COUNT_MAX) + 64'd1);
  localparam int unsigned LW = $clog2(65'(LINE_COUNT_MAX) + 65'd1);

  typedef struct packed {
    logic          inside_quotes;
    logic          quote_pending;
    logic          inside_comment;
    logic          line_has_content;
    logic [FW-1:0] field_cnt;
    logic [LW-1:0] line_cnt;
  } st_t;

  typedef struct packed {
    st_t                 st;
    logic                emit;
    qdfs_pkg::out_item_t item;
  } step_t;

  function automatic step_t take(input st_t s, input logic [7:0] b, input qdfs_pkg::cfg_t c);
    step_t       r;
    logic [63:0] f64;
    logic [63:0] l64;
    logic        handled;
    f64 = 64'(s.field_cnt);
    l64 = 64'(s.line_cnt);
    handled = 1'b0;
    r.st = s;
    r.emit = 1'b0;
    r.item = '0;
    r.item.field_number = f64[7:0];
    r.item.line_number = l64[15:0];
    if (b == qdfs_pkg::CR_BYTE) begin
      r.emit = 1'b0;
    end else if (b == qdfs_pkg::LF_BYTE) begin
      r.emit = 1'b1;
      r.item.kind = qdfs_pkg::KIND_LINE_END;
      r.item.line_blank = ~s.line_has_content;
      if (s.line_has_content && (s.line_cnt < LW'(LINE_COUNT_MAX))) begin
        r.st.line_cnt = s.line_cnt + LW'(1);
      end
      r.st.field_cnt = '0;
      r.st.inside_quotes = 1'b0;
      r.st.quote_pending = 1'b0;
      r.st.inside_comment = 1'b0;
      r.st.line_has_content = 1'b0;
    end else if (!s.inside_comment) begin
      if (s.quote_pending) begin
        r.st.quote_pending = 1'b0;
        if (b == qdfs_pkg::QUOTE_BYTE) begin
          r.emit = 1'b1;
          r.item.kind = qdfs_pkg::KIND_CONTENT;
          r.item.data_byte = qdfs_pkg::QUOTE_BYTE;
          r.st.line_has_content = 1'b1;
          handled = 1'b1;
        end else begin
          r.st.inside_quotes = 1'b0;
        end
      end
      if (!handled) begin
        if (r.st.inside_quotes) begin
          if (b == qdfs_pkg::QUOTE_BYTE) begin
            r.st.quote_pending = 1'b1;
            r.st.line_has_content = 1'b1;
          end else begin
            r.emit = 1'b1;
            r.item.kind = qdfs_pkg::KIND_CONTENT;
            r.item.data_byte = b;
            if (b != qdfs_pkg::SPACE_BYTE && b != qdfs_pkg::TAB_BYTE) begin
              r.st.line_has_content = 1'b1;
            end
          end
        end else if (b == qdfs_pkg::QUOTE_BYTE) begin
          r.st.inside_quotes = 1'b1;
          r.st.line_has_content = 1'b1;
        end else if (b == c.comment_char) begin
          r.st.inside_comment = 1'b1;
        end else if (b == c.delimiter_char) begin
          r.emit = 1'b1;
          r.item.kind = qdfs_pkg::KIND_FIELD_END;
          r.st.line_has_content = 1'b1;
          if (s.field_cnt < FW'(FIELD_COUNT_MAX)) begin
            r.st.field_cnt = s.field_cnt + FW'(1);
          end
        end else begin
          r.emit = 1'b1;
          r.item.kind = qdfs_pkg::KIND_CONTENT;
          r.item.data_byte = b;
          if (b != qdfs_pkg::SPACE_BYTE && b != qdfs_pkg::TAB_BYTE) begin
            r.st.line_has_content = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  st_t   st_r;
  st_t   st_nxt;
  step_t step_a;
  step_t step_b;

  always_comb begin
    step_a = take(st_r, in_item.in_byte, cfg);
    step_b = take(step_a.st, qdfs_pkg::LF_BYTE, cfg);
    st_nxt = in_item.end_of_file ? step_b.st : step_a.st;

    results.push0 = accept & (step_a.emit | in_item.end_of_file);
    results.push1 = accept & step_a.emit & in_item.end_of_file;
    results.item0 = step_a.emit ? step_a.item : step_b.item;
    results.item0.last_of_run = ~(step_a.emit & in_item.end_of_file);
    results.item1 = step_b.item;
    results.item1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/qdfs_out_queue.sv -----
// Four-entry result queue: two writes and one read per cycle.
`default_nettype none
module qdfs_out_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire qdfs_pkg::result_pair_t results,
  input  wire logic                   pop,
  output logic                        not_empty,
  output logic                        room_two,
  output qdfs_pkg::out_item_t         head
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  qdfs_pkg::out_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [PW-1:0] wr_ptr_nxt;

  assign not_empty = (count_r != '0);
  assign room_two  = (count_r <= CW'(DEPTH - 2));
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + CW'(results.push0) + CW'(results.push1) - CW'(pop);
    wr_ptr_nxt = wr_ptr_r + PW'(results.push0) + PW'(results.push1);
  end

  always_ff @(posedge clk) begin
    if (results.push0) begin
      mem_r[wr_ptr_r] <= results.item0;
    end
    if (results.push1) begin
      mem_r[wr_ptr_r + PW'(1)] <= results.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/quoted_delimited_field_splitter_core.sv -----
// Top level of the quoted delimited field splitter.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall    qdfs_pkg::in_item_t
//   out_     output     out_valid / out_stall  qdfs_pkg::out_item_t
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle unless in_stall; its results enter a four-entry
// queue at the same edge and reach out_ from the next cycle at the earliest.
// out_ gives one result per cycle while out_stall is low. An end_of_file byte
// that also emits on its own gives two results.
// in_stall is high while fewer than two queue slots are free.
// Synchronous reset clears parse state and queue; registers get reset values.
`default_nettype none
module quoted_delimited_field_splitter_core #(
  parameter int unsigned     FIELD_COUNT_MAX = 255,
  parameter longint unsigned LINE_COUNT_MAX  = 65535
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire qdfs_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output qdfs_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [qdfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                       cfg_data
);

  qdfs_pkg::cfg_t         cfg_r;
  qdfs_pkg::result_pair_t results;
  logic                   accept;
  logic                   pop;
  logic                   room_two;

  assign cfg_ready = 1'b1;
  assign in_stall  = ~room_two;
  assign accept    = in_valid & room_two;
  assign pop       = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter_char <= qdfs_pkg::DELIMITER_RESET;
      cfg_r.comment_char   <= qdfs_pkg::COMMENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qdfs_pkg::REG_DELIMITER: cfg_r.delimiter_char <= cfg_data;
        qdfs_pkg::REG_COMMENT:   cfg_r.comment_char   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  qdfs_parser #(
    .FIELD_COUNT_MAX(FIELD_COUNT_MAX),
    .LINE_COUNT_MAX (LINE_COUNT_MAX)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_item(in_data),
    .cfg    (cfg_r),
    .results(results)
  );

  qdfs_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .results  (results),
    .pop      (pop),
    .not_empty(out_valid),
    .room_two (room_two),
    .head     (out_data)
  );

endmodule
`default_nettype wire

// ----- sim/quoted_delimited_field_splitter_core_tb.sv -----
// Self-checking testbench for the quoted delimited field splitter core.
module quoted_delimited_field_splitter_core_tb;

  localparam logic [7:0]  FIELD_LIMIT = 8'd255;
  localparam logic [15:0] LINE_LIMIT  = 16'hFFFF;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  qdfs_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  qdfs_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [qdfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                     cfg_data = '0;

  quoted_delimited_field_splitter_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser state mirror
  logic [7:0]  cfg_delim = qdfs_pkg::DELIMITER_RESET;
  logic [7:0]  cfg_comment = qdfs_pkg::COMMENT_RESET;
  logic        q_open = 1'b0;
  logic        q_pending = 1'b0;
  logic        in_remark = 1'b0;
  logic        line_nonblank = 1'b0;
  logic [7:0]  field_idx = '0;
  logic [15:0] line_idx = '0;

  qdfs_pkg::out_item_t expected_tokens[$];
  int unsigned failures = 0;
  int unsigned items_sent = 0;

  bit          tx_jitter = 1'b0;
  bit          rx_jitter = 1'b0;
  bit          rx_hold = 1'b0;
  int unsigned rx_burst = 0;

  function automatic void push_token(input logic [1:0] kind, input logic [7:0] data,
                                     input logic blank);
    qdfs_pkg::out_item_t t;
    t.kind = kind;
    t.data_byte = data;
    t.line_blank = blank;
    t.field_number = field_idx;
    t.line_number = line_idx;
    t.last_of_run = 1'b0;
    expected_tokens = {expected_tokens, t};
  endfunction

  function automatic void split_byte(input logic [7:0] b);
    if (b == qdfs_pkg::CR_BYTE) return;
    if (b == qdfs_pkg::LF_BYTE) begin
      push_token(qdfs_pkg::KIND_LINE_END, 8'h00, !line_nonblank);
      if (line_nonblank && line_idx != LINE_LIMIT) line_idx = line_idx + 16'd1;
      field_idx = '0;
      q_open = 1'b0;
      q_pending = 1'b0;
      in_remark = 1'b0;
      line_nonblank = 1'b0;
      return;
    end
    if (in_remark) return;
    if (q_pending) begin
      q_pending = 1'b0;
      if (b == qdfs_pkg::QUOTE_BYTE) begin
        push_token(qdfs_pkg::KIND_CONTENT, qdfs_pkg::QUOTE_BYTE, 1'b0);
        line_nonblank = 1'b1;
        return;
      end
      q_open = 1'b0;
    end
    if (q_open) begin
      if (b == qdfs_pkg::QUOTE_BYTE) begin
        q_pending = 1'b1;
        line_nonblank = 1'b1;
        return;
      end
      push_token(qdfs_pkg::KIND_CONTENT, b, 1'b0);
      if (b != qdfs_pkg::SPACE_BYTE && b != qdfs_pkg::TAB_BYTE) line_nonblank = 1'b1;
      return;
    end
    if (b == qdfs_pkg::QUOTE_BYTE) begin
      q_open = 1'b1;
      line_nonblank = 1'b1;
      return;
    end
    if (b == cfg_comment) begin
      in_remark = 1'b1;
      return;
    end
    if (b == cfg_delim) begin
      push_token(qdfs_pkg::KIND_FIELD_END, 8'h00, 1'b0);
      line_nonblank = 1'b1;
      if (field_idx != FIELD_LIMIT) field_idx = field_idx + 8'd1;
      return;
    end
    push_token(qdfs_pkg::KIND_CONTENT, b, 1'b0);
    if (b != qdfs_pkg::SPACE_BYTE && b != qdfs_pkg::TAB_BYTE) line_nonblank = 1'b1;
  endfunction

  function automatic void predict_item(input qdfs_pkg::in_item_t it);
    int unsigned n0;
    n0 = expected_tokens.size();
    split_byte(it.in_byte);
    if (it.end_of_file) split_byte(qdfs_pkg::LF_BYTE);
    if (expected_tokens.size() > n0) begin
      expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
    if (got_v !== want_v) begin
      failures++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin : result_check
    qdfs_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          failures++;
          $display("%0t: unexpected transfer: expected none, actual %h", $time, out_data);
        end else begin
          want = expected_tokens.pop_front();
          compare_field("kind", 16'(want.kind), 16'(out_data.kind));
          compare_field("data_byte", 16'(want.data_byte), 16'(out_data.data_byte));
          compare_field("line_blank", 16'(want.line_blank), 16'(out_data.line_blank));
          compare_field("field_number", 16'(want.field_number),
                        16'(out_data.field_number));
          compare_field("line_number", want.line_number, out_data.line_number);
          compare_field("last_of_run", 16'(want.last_of_run), 16'(out_data.last_of_run));
        end
      end
      if (in_valid && !in_stall) predict_item(in_data);
    end
  end

  always @(posedge clk) begin
    if (rx_hold) begin
      out_stall <= 1'b1;
    end else if (rx_burst != 0) begin
      out_stall <= 1'b1;
      rx_burst <= rx_burst - 1;
    end else if (rx_jitter && $urandom_range(0, 6) == 0) begin
      out_stall <= 1'b1;
      rx_burst <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (tx_jitter && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, end_of_file: eof};
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic cfg_write(input logic [qdfs_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == qdfs_pkg::REG_DELIMITER) cfg_delim = val;
    else if (idx == qdfs_pkg::REG_COMMENT) cfg_comment = val;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_chars(input logic [7:0] d, input logic [7:0] c);
    settle();
    cfg_write(qdfs_pkg::REG_DELIMITER, d);
    cfg_write(qdfs_pkg::REG_COMMENT, c);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_text();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'(8'h61 + $urandom_range(0, 25));
      4: return $urandom_range(0, 1) ? qdfs_pkg::SPACE_BYTE : qdfs_pkg::TAB_BYTE;
      5: return cfg_delim;
      6: return cfg_comment;
      7: return qdfs_pkg::CR_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // record-shaped line: fields, optional quoting with doubled quotes, optional comment
  task automatic send_record();
    int unsigned nf;
    int unsigned len;
    nf = $urandom_range(1, 4);
    if ($urandom_range(0, 3) == 0) send_byte(qdfs_pkg::SPACE_BYTE, 1'b0);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) send_byte(cfg_delim, 1'b0);
      len = $urandom_range(0, 5);
      if ($urandom_range(0, 2) == 0) begin
        send_byte(qdfs_pkg::QUOTE_BYTE, 1'b0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_byte(qdfs_pkg::QUOTE_BYTE, 1'b0);
            send_byte(qdfs_pkg::QUOTE_BYTE, 1'b0);
          end else begin
            send_byte(pick_text(), 1'b0);
          end
        end
        send_byte(qdfs_pkg::QUOTE_BYTE, 1'b0);
      end else begin
        for (int i = 0; i < len; i++) send_byte(pick_text(), 1'b0);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      send_byte(cfg_comment, 1'b0);
      repeat ($urandom_range(0, 3)) send_byte(pick_text(), 1'b0);
    end
    if ($urandom_range(0, 9) == 0) begin
      send_byte(pick_text(), 1'b1);
    end else begin
      if ($urandom_range(0, 2) == 0) send_byte(qdfs_pkg::CR_BYTE, 1'b0);
      send_byte(qdfs_pkg::LF_BYTE, 1'b0);
    end
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 3))
        0: b = qdfs_pkg::QUOTE_BYTE;
        1: b = qdfs_pkg::LF_BYTE;
        default: b = pick_text();
      endcase
      send_byte(b, $urandom_range(0, 29) == 0);
    end
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(qdfs_pkg::DELIMITER_RESET, 1'b0);
    send_byte(qdfs_pkg::QUOTE_BYTE, 1'b0);
    send_byte(qdfs_pkg::COMMENT_RESET, 1'b0);
    send_byte(qdfs_pkg::QUOTE_BYTE, 1'b0);
    send_byte(qdfs_pkg::CR_BYTE, 1'b0);
    send_byte(qdfs_pkg::QUOTE_BYTE, 1'b0);
    send_byte(qdfs_pkg::QUOTE_BYTE, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(qdfs_pkg::COMMENT_RESET, 1'b0);
    send_byte(qdfs_pkg::DELIMITER_RESET, 1'b0);
    send_byte(qdfs_pkg::CR_BYTE, 1'b0);
    send_byte(qdfs_pkg::LF_BYTE, 1'b0);
    send_byte(qdfs_pkg::SPACE_BYTE, 1'b0);
    send_byte(qdfs_pkg::TAB_BYTE, 1'b0);
    send_byte(qdfs_pkg::LF_BYTE, 1'b0);
    send_byte(qdfs_pkg::COMMENT_RESET, 1'b0);
    send_byte(qdfs_pkg::LF_BYTE, 1'b0);
    send_byte(8'h71, 1'b1);
    send_byte(qdfs_pkg::LF_BYTE, 1'b1);
    send_byte(qdfs_pkg::QUOTE_BYTE, 1'b1);
    settle();
  endtask

  task automatic test_field_saturation();
    send_byte(8'h66, 1'b0);
    repeat (260) send_byte(cfg_delim, 1'b0);
    send_byte(8'h67, 1'b0);
    send_byte(qdfs_pkg::LF_BYTE, 1'b0);
    settle();
  endtask

  // output held off long enough that the result queue fills and input stalls
  task automatic test_backpressure();
    tx_jitter = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (80) @(posedge clk);
        rx_hold <= 1'b0;
      end
      repeat (40) send_byte(pick_text(), $urandom_range(0, 7) == 0);
    join
    settle();
  endtask

  task automatic test_config_sweep();
    logic [7:0]  d;
    logic [7:0]  c;
    int unsigned stop;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin d = qdfs_pkg::DELIMITER_RESET; c = qdfs_pkg::COMMENT_RESET; end
        1: begin d = 8'h00; c = 8'hFF; end
        2: begin d = 8'hFF; c = 8'h00; end
        3: begin d = qdfs_pkg::QUOTE_BYTE; c = qdfs_pkg::LF_BYTE; end
        4: begin d = 8'h2C; c = 8'h2C; end
        5: begin d = qdfs_pkg::CR_BYTE; c = qdfs_pkg::SPACE_BYTE; end
        default: begin d = 8'($urandom_range(0, 255)); c = 8'($urandom_range(0, 255)); end
      endcase
      set_chars(d, c);
      tx_jitter = (ph != 4);
      rx_jitter <= (ph != 4);
      stop = items_sent + 40;
      while (items_sent < stop) begin
        if ($urandom_range(0, 3) != 0) send_record();
        else send_noise();
      end
    end
    settle();
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_stream();
    int unsigned stop;
    set_chars(qdfs_pkg::DELIMITER_RESET, qdfs_pkg::COMMENT_RESET);
    tx_jitter = 1'b0;
    rx_jitter <= 1'b0;
    stop = items_sent + 50;
    while (items_sent < stop) send_record();
    send_byte(8'h7A, 1'b1);
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_jitter = 1'b1;
    rx_jitter <= 1'b1;
    test_directed();
    test_field_saturation();
    test_backpressure();
    test_config_sweep();
    test_steady_stream();
    repeat (8) @(posedge clk);
    if (failures == 0 && expected_tokens.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
